// ===== hw/rtl/mmsp_pkg.sv =====
package mmsp_pkg;

    localparam int DEF_MAX_TOKEN_BYTES   = 60;
    localparam int DEF_HEADER_LIMIT_BITS = 13;
    localparam int DEF_MAX_HEADER_BYTES  = 4092;

    localparam int TOK_IDX_W = 6;
    localparam int POS_W     = 7;
    localparam int PARTS_W   = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [7:0]  CHR_CR      = 8'h0D;
    localparam logic [7:0]  CHR_LF      = 8'h0A;
    localparam logic [7:0]  CHR_DASH    = 8'h2D;
    localparam logic [31:0] SECTION_END = 32'h0D0A0D0A;

    localparam logic CMD_STREAM = 1'b0;
    localparam logic CMD_TOKEN  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOUNDARY_LEN     = 1'b0,
        CFG_MAX_HEADER_BYTES = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        M_BOUNDARY = 3'd0,
        M_AFTER    = 3'd1,
        M_HEADERS  = 3'd2,
        M_BODY     = 3'd3,
        M_DONE     = 3'd4,
        M_ERROR    = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        K_HDR  = 3'd0,
        K_BODY = 3'd1,
        K_HEND = 3'd2,
        K_PEND = 3'd3,
        K_DONE = 3'd4,
        K_ERR  = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_FLUSH = 2'd1,
        S_TAIL  = 2'd2
    } t_state;

    typedef struct packed {
        logic                 cmd;
        logic [7:0]           byte_in;
        logic [TOK_IDX_W-1:0] token_index;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]         kind;
        logic [7:0]         byte_out;
        logic [PARTS_W-1:0] part_number;
        logic               last;
    } t_out_beat;

    typedef struct packed {
        logic step;
        logic flush_start;
        logic flush_emit;
        logic tail_emit;
        logic rd_flush;
    } t_dp_cmd;

    typedef struct packed {
        logic slot_free;
        logic need_flush;
        logic flush_last;
        logic tail_silent;
    } t_dp_stat;

endpackage

// ===== hw/rtl/mmsp_ctrl.sv =====
module mmsp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mmsp_pkg::t_dp_stat  i_stat,
    output mmsp_pkg::t_dp_cmd   o_cmd
);
    import mmsp_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_in_valid && (r_state == S_IDLE) && i_stat.slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_stat.need_flush) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (i_stat.slot_free && i_stat.flush_last) begin
                    n_state = i_stat.tail_silent ? S_IDLE : S_TAIL;
                end
            end
            S_TAIL: begin
                if (i_stat.slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready        = (r_state == S_IDLE) && i_stat.slot_free;
        o_cmd.step        = accept && !i_stat.need_flush;
        o_cmd.flush_start = accept && i_stat.need_flush;
        o_cmd.flush_emit  = (r_state == S_FLUSH) && i_stat.slot_free;
        o_cmd.tail_emit   = (r_state == S_TAIL) && i_stat.slot_free;
        o_cmd.rd_flush    = (n_state == S_FLUSH);
    end

endmodule

// ===== hw/rtl/mmsp_dpath.sv =====
module mmsp_dpath #(
    parameter int MAX_TOKEN_BYTES   = mmsp_pkg::DEF_MAX_TOKEN_BYTES,
    parameter int HEADER_LIMIT_BITS = mmsp_pkg::DEF_HEADER_LIMIT_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mmsp_pkg::t_in_beat                i_in,
    input  logic                              i_cfg_valid,
    input  logic [mmsp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [HEADER_LIMIT_BITS-1:0]      i_cfg_data,
    input  mmsp_pkg::t_dp_cmd                 i_cmd,
    output mmsp_pkg::t_dp_stat                o_stat,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output mmsp_pkg::t_out_beat               o_out
);
    import mmsp_pkg::*;

    localparam int TA_W = (MAX_TOKEN_BYTES > 1) ? $clog2(MAX_TOKEN_BYTES) : 1;
    localparam int HC_W = HEADER_LIMIT_BITS;
    localparam logic [HC_W-1:0] MHB_RST = HC_W'(DEF_MAX_HEADER_BYTES);

    logic [7:0]         r_mem [MAX_TOKEN_BYTES];
    logic [7:0]         r_tok;

    logic [5:0]         r_blen;
    logic [HC_W-1:0]    r_mhb;

    t_mode              r_mode,    n_mode;
    logic [POS_W-1:0]   r_pos,     n_pos;
    logic [PARTS_W-1:0] r_parts,   n_parts;
    logic               r_in_body, n_in_body;
    logic               r_dash,    n_dash;
    logic               r_trail,   n_trail;
    logic [23:0]        r_tw,      n_tw;
    logic [HC_W-1:0]    r_hc,      n_hc;
    logic [7:0]         r_byte,    n_byte;
    logic [POS_W-1:0]   r_fidx,    n_fidx;

    logic               r_out_valid;
    t_out_beat          r_out;

    logic               emit;
    t_kind              e_kind;
    logic [7:0]         e_byte;
    logic               e_last;

    logic               pre4;
    logic [POS_W-1:0]   pre;
    logic [POS_W-1:0]   tlen;
    logic [POS_W-1:0]   size;
    logic [POS_W-1:0]   pos_inc;
    logic [7:0]         b;
    logic [7:0]         cur_sample;
    logic               match;
    logic [31:0]        tw_full;
    logic [HC_W:0]      hc_inc;
    logic [PARTS_W-1:0] parts_inc;
    logic               flush_last;
    logic               tail_silent;
    logic               slot_free;

    logic               rd_pre4;
    logic [POS_W-1:0]   rd_pos;
    logic [POS_W-1:0]   rd_diff;
    logic               rd_en;
    logic               tok_we;

    function automatic logic [7:0] f_sample(input logic [POS_W-1:0] pos,
                                            input logic             p4,
                                            input logic [7:0]       tok);
        logic [7:0] s;
        if (!p4) begin
            s = (pos < POS_W'(2)) ? CHR_DASH : tok;
        end else if (pos < POS_W'(4)) begin
            case (pos[1:0])
                2'd0:    s = CHR_CR;
                2'd1:    s = CHR_LF;
                default: s = CHR_DASH;
            endcase
        end else begin
            s = tok;
        end
        return s;
    endfunction

    assign b          = i_in.byte_in;
    assign pre4       = (r_parts != '0);
    assign pre        = pre4 ? POS_W'(4) : POS_W'(2);
    assign tlen       = (r_blen == '0) ? POS_W'(1) :
                        (POS_W'(r_blen) > POS_W'(MAX_TOKEN_BYTES)) ? POS_W'(MAX_TOKEN_BYTES) :
                        POS_W'(r_blen);
    assign size       = pre + tlen;
    assign pos_inc    = r_pos + POS_W'(1);
    assign cur_sample = f_sample(r_pos, pre4, r_tok);
    assign match      = (r_pos < size) && (cur_sample == b);
    assign tw_full    = {r_tw, b};
    assign hc_inc     = {1'b0, r_hc} + (HC_W+1)'(1);
    assign parts_inc  = (r_parts == '1) ? r_parts : r_parts + PARTS_W'(1);
    assign flush_last = (r_fidx == r_pos - POS_W'(1));
    assign tail_silent = (r_byte == CHR_CR) && pre4;
    assign slot_free  = !r_out_valid || i_out_ready;

    always_comb begin
        o_stat.slot_free   = slot_free;
        o_stat.need_flush  = (i_in.cmd == CMD_STREAM) && (r_mode == M_BOUNDARY) && !match &&
                             r_in_body && (r_pos != '0);
        o_stat.flush_last  = flush_last;
        o_stat.tail_silent = tail_silent;
    end

    always_comb begin
        n_mode    = r_mode;
        n_pos     = r_pos;
        n_parts   = r_parts;
        n_in_body = r_in_body;
        n_dash    = r_dash;
        n_trail   = r_trail;
        n_tw      = r_tw;
        n_hc      = r_hc;
        n_byte    = r_byte;
        n_fidx    = r_fidx;
        emit      = 1'b0;
        e_kind    = K_BODY;
        e_byte    = '0;
        e_last    = 1'b1;

        if (i_cmd.step) begin
            if (i_in.cmd == CMD_TOKEN) begin
                n_mode    = M_BOUNDARY;
                n_pos     = '0;
                n_parts   = '0;
                n_in_body = 1'b0;
                n_dash    = 1'b0;
                n_trail   = 1'b0;
                n_tw      = '0;
                n_hc      = '0;
            end else begin
                unique case (r_mode)
                    M_BOUNDARY: begin
                        if (match) begin
                            n_pos = pos_inc;
                            if (pos_inc >= size) begin
                                n_mode    = M_AFTER;
                                n_pos     = '0;
                                n_in_body = 1'b0;
                                n_trail   = 1'b0;
                                if (pre4) begin
                                    emit   = 1'b1;
                                    e_kind = K_PEND;
                                end
                            end
                        end else if (!r_in_body) begin
                            n_mode = M_ERROR;
                            emit   = 1'b1;
                            e_kind = K_ERR;
                        end else begin
                            n_mode = M_BODY;
                            emit   = 1'b1;
                            e_kind = K_BODY;
                            e_byte = b;
                        end
                    end
                    M_AFTER: begin
                        if (!r_trail) begin
                            if (b == CHR_DASH) begin
                                n_dash  = 1'b1;
                                n_trail = 1'b1;
                            end else if (b == CHR_CR) begin
                                n_dash  = 1'b0;
                                n_trail = 1'b1;
                            end else begin
                                n_mode = M_ERROR;
                                emit   = 1'b1;
                                e_kind = K_ERR;
                            end
                        end else begin
                            n_trail = 1'b0;
                            if (r_dash && (b == CHR_DASH)) begin
                                n_mode = M_DONE;
                                emit   = 1'b1;
                                e_kind = K_DONE;
                            end else if (!r_dash && (b == CHR_LF)) begin
                                n_mode = M_HEADERS;
                                n_tw   = '0;
                                n_hc   = '0;
                            end else begin
                                n_mode = M_ERROR;
                                emit   = 1'b1;
                                e_kind = K_ERR;
                            end
                        end
                    end
                    M_HEADERS: begin
                        n_tw = tw_full[23:0];
                        if (tw_full == SECTION_END) begin
                            if (r_hc > r_mhb) begin
                                n_mode = M_ERROR;
                                emit   = 1'b1;
                                e_kind = K_ERR;
                            end else begin
                                n_parts = parts_inc;
                                n_mode  = M_BODY;
                                emit    = 1'b1;
                                e_kind  = K_HEND;
                            end
                        end else if (hc_inc > {1'b0, r_mhb}) begin
                            n_mode = M_ERROR;
                            emit   = 1'b1;
                            e_kind = K_ERR;
                        end else begin
                            n_hc   = hc_inc[HC_W-1:0];
                            emit   = 1'b1;
                            e_kind = K_HDR;
                            e_byte = b;
                        end
                    end
                    M_BODY: begin
                        if ((b == CHR_CR) && pre4) begin
                            n_mode    = M_BOUNDARY;
                            n_in_body = 1'b1;
                            n_pos     = POS_W'(1);
                        end else begin
                            if (b == CHR_CR) begin
                                n_in_body = 1'b1;
                                n_pos     = '0;
                            end
                            n_mode = M_BODY;
                            emit   = 1'b1;
                            e_kind = K_BODY;
                            e_byte = b;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (i_cmd.flush_start) begin
            n_byte = b;
            n_fidx = '0;
        end

        if (i_cmd.flush_emit) begin
            emit   = 1'b1;
            e_kind = K_BODY;
            e_byte = f_sample(r_fidx, pre4, r_tok);
            e_last = flush_last && tail_silent;
            n_fidx = r_fidx + POS_W'(1);
            if (flush_last) begin
                n_pos  = tail_silent ? POS_W'(1) : '0;
                n_mode = tail_silent ? M_BOUNDARY : M_BODY;
            end
        end

        if (i_cmd.tail_emit) begin
            emit   = 1'b1;
            e_kind = K_BODY;
            e_byte = r_byte;
        end
    end

    // prefetch the token byte that the next match position or flush position needs
    assign rd_pre4 = (n_parts != '0);
    assign rd_pos  = i_cmd.rd_flush ? n_fidx : n_pos;
    assign rd_diff = rd_pos - (rd_pre4 ? POS_W'(4) : POS_W'(2));
    assign rd_en   = (rd_pos >= (rd_pre4 ? POS_W'(4) : POS_W'(2))) &&
                     (rd_diff < POS_W'(MAX_TOKEN_BYTES));
    assign tok_we  = i_cmd.step && (i_in.cmd == CMD_TOKEN) &&
                     (i_in.token_index < TOK_IDX_W'(MAX_TOKEN_BYTES));

    always_ff @(posedge i_clk) begin
        if (tok_we) begin
            r_mem[i_in.token_index[TA_W-1:0]] <= i_in.byte_in;
        end
        if (rd_en) begin
            r_tok <= r_mem[rd_diff[TA_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blen <= 6'd1;
            r_mhb  <= MHB_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BOUNDARY_LEN:     r_blen <= i_cfg_data[5:0];
                CFG_MAX_HEADER_BYTES: r_mhb  <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_BOUNDARY;
            r_pos       <= '0;
            r_parts     <= '0;
            r_in_body   <= 1'b0;
            r_dash      <= 1'b0;
            r_trail     <= 1'b0;
            r_tw        <= '0;
            r_hc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode    <= n_mode;
            r_pos     <= n_pos;
            r_parts   <= n_parts;
            r_in_body <= n_in_body;
            r_dash    <= n_dash;
            r_trail   <= n_trail;
            r_tw      <= n_tw;
            r_hc      <= n_hc;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_fidx <= n_fidx;
        if (emit) begin
            r_out.kind        <= e_kind;
            r_out.byte_out    <= e_byte;
            r_out.part_number <= n_parts;
            r_out.last        <= e_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== hw/rtl/multipart_mime_stream_parser_core.sv =====
// Multipart MIME deframer, one stream byte per input beat.
// Input channel (i_in_valid/o_in_ready, i_in): cmd 0 carries a stream byte,
// cmd 1 writes one boundary token byte at token_index and restarts the parser.
// Output channel (o_out_valid/i_out_ready, o_out): one beat per event (header
// byte, body byte, headers end, part end, done, error); last marks the final
// beat caused by one input beat.
// Config channel (i_cfg_valid/o_cfg_ready): index 0 boundary_len, index 1
// max_header_bytes; write only while the parser is idle.
// A result is registered on o_out in the cycle after its input beat is taken;
// the first beat of a replayed prefix is emitted from the flush state first.
// Throughput: one input beat per cycle while the output is drained. A body
// CR that starts a boundary match which later fails replays the matched
// prefix: the k matched bytes are emitted one by one, then the failing byte
// too when it is a body byte; input is held off meanwhile. The token
// read port of the boundary store is prefetched for the next position.
// Reset clears parser state and config (boundary_len 1, max_header_bytes
// 4092); token bytes are undefined until written.
// When the receiver stalls, the output register holds its beat and input
// is refused until the register can take the next result.
module multipart_mime_stream_parser_core #(
    parameter int MAX_TOKEN_BYTES   = mmsp_pkg::DEF_MAX_TOKEN_BYTES,
    parameter int HEADER_LIMIT_BITS = mmsp_pkg::DEF_HEADER_LIMIT_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  mmsp_pkg::t_in_beat                i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output mmsp_pkg::t_out_beat               o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mmsp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [HEADER_LIMIT_BITS-1:0]      i_cfg_data
);
    import mmsp_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    assign o_cfg_ready = 1'b1;

    mmsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    mmsp_dpath #(
        .MAX_TOKEN_BYTES   (MAX_TOKEN_BYTES),
        .HEADER_LIMIT_BITS (HEADER_LIMIT_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule
